### src/ssmt_pkg.sv
// ----------------------------------------------------------------------------
// ssmt_pkg: shared types for the set membership table
// Request kinds, status codes and the control token passed along the cell row.
// ----------------------------------------------------------------------------
package ssmt_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CHECK  = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_REMOVED = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_MEMBER  = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  // Control half of the walking token; the value travels alongside.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       found;   // value matched at this cell or upstream
    logic       placed;  // add already wrote the value into a free cell
  } tok_t;

endpackage

### src/small_set_membership_table_top.sv
// ----------------------------------------------------------------------------
// small_set_membership_table_top: bounded set with add, remove and check
// Flow: the token of an accepted request walks the cell row one cell per cycle;
//   its outcome is registered as pending, then moved to the response register.
//   A new request is stalled until the last one's result has made that move.
// Reset: clears the item count, every cell's occupied flag and all handshake
//   state; entry words are not cleared (an unoccupied cell is never matched).
// ----------------------------------------------------------------------------
module small_set_membership_table_top
  import ssmt_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    req_type,
  input  logic [31:0]                   item_value,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [2:0]                    status,
  output logic [$clog2(CAPACITY+1)-1:0] item_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  // Token row: tok[i] feeds cell i, tok[CAPACITY] leaves the last cell.
  tok_t                  tok   [0:CAPACITY];
  logic [ITEM_WIDTH-1:0] val   [0:CAPACITY];
  logic [ITEM_WIDTH-1:0] entry [0:CAPACITY];
  logic                  occ   [0:CAPACITY];

  logic          busy;       // a request is in the row or parked
  logic          accept;
  logic          pend_valid; // finished request waiting for the output register
  status_t       pend_status;
  logic [CW-1:0] pend_count;
  logic          move;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  status_t       status_next;

  assign req_stall = busy;
  assign accept    = req_valid && !busy;

  // Injection into cell 0 straight from the port on the accept edge.
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = accept;
    tok[0].kind   = req_type;
    val[0]        = ITEM_WIDTH'(item_value);
    entry[CAPACITY] = '0;   // nothing beyond the last cell
    occ[CAPACITY]   = 1'b0;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssmt_cell #(
      .ITEM_WIDTH(ITEM_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[i]),
      .val_in   (val[i]),
      .nxt_entry(entry[i+1]),
      .nxt_occ  (occ[i+1]),
      .tok_out  (tok[i+1]),
      .val_out  (val[i+1]),
      .entry    (entry[i]),
      .occ      (occ[i])
    );
  end

  // Outcome once the token has passed every cell.
  always_comb begin
    count_next = count;
    case (tok[CAPACITY].kind)
      REQ_ADD: begin
        if (tok[CAPACITY].found) begin
          status_next = ST_PRESENT;
        end else if (tok[CAPACITY].placed) begin
          status_next = ST_ADDED;
          count_next  = count + CW'(1);
        end else begin
          status_next = ST_FULL;    // no free cell left
        end
      end
      REQ_REMOVE: begin
        if (tok[CAPACITY].found) begin
          status_next = ST_REMOVED;
          count_next  = count - CW'(1);
        end else begin
          status_next = ST_ABSENT;
        end
      end
      default: begin
        // check, and the unused code that acts as check
        status_next = tok[CAPACITY].found ? ST_MEMBER : ST_ABSENT;
      end
    endcase
  end

  assign move = pend_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      count      <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (tok[CAPACITY].valid) begin
        pend_valid <= 1'b1;
        count      <= count_next;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (tok[CAPACITY].valid) begin
      pend_status <= status_next;
      pend_count  <= count_next;
    end
    if (move) begin
      status     <= pend_status;
      item_count <= pend_count;
    end
  end

endmodule

### src/ssmt_cell.sv
// ----------------------------------------------------------------------------
// ssmt_cell: one slot of the set
// Holds one entry, compares the passing token against it, takes the neighbor
// entry on a remove shift, or claims the value on an add at the first free slot.
// ----------------------------------------------------------------------------
module ssmt_cell
  import ssmt_pkg::*;
#(
  parameter int ITEM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tok_t                  tok_in,
  input  logic [ITEM_WIDTH-1:0] val_in,
  input  logic [ITEM_WIDTH-1:0] nxt_entry,
  input  logic                  nxt_occ,
  output tok_t                  tok_out,
  output logic [ITEM_WIDTH-1:0] val_out,
  output logic [ITEM_WIDTH-1:0] entry,
  output logic                  occ
);

  logic hit;
  logic shift;
  logic place;
  tok_t tok_next;

  always_comb begin
    hit   = tok_in.valid && occ && (entry == val_in);
    shift = tok_in.valid && (tok_in.kind == REQ_REMOVE) && (tok_in.found || hit);
    // packed set: first free cell ends the held run, so no match can follow it
    place = tok_in.valid && (tok_in.kind == REQ_ADD) && !occ &&
            !tok_in.found && !tok_in.placed;
    tok_next        = tok_in;
    tok_next.found  = tok_in.found || hit;
    tok_next.placed = tok_in.placed || place;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (shift) begin
        occ <= nxt_occ;
      end else if (place) begin
        occ <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_out <= val_in;
    if (shift) begin
      entry <= nxt_entry;
    end else if (place) begin
      entry <= val_in;
    end
  end

endmodule
